>>> rtl/ssp_pkg.sv
// Shared types and constants for the sprite screen projection block.
// No dependencies; imported by the projection pipeline.
`default_nettype none

package ssp_pkg;

   // configuration register indexes
   localparam logic [2:0] CSR_DIR_X       = 3'd0;
   localparam logic [2:0] CSR_DIR_Y       = 3'd1;
   localparam logic [2:0] CSR_PLANE_X     = 3'd2;
   localparam logic [2:0] CSR_PLANE_Y     = 3'd3;
   localparam logic [2:0] CSR_VIEW_OFFSET = 3'd4;

   // register reset values
   localparam logic signed [15:0] DIR_X_RESET   = 16'sd16384;
   localparam logic signed [15:0] PLANE_Y_RESET = 16'sd10813;

   // long division: quotient bits, one per stage
   localparam int DIV_STEPS = 21;
   localparam int REM_W     = 64;
   localparam int DEN_W     = 41;

   // horizontal position clamp before the wobble is added
   localparam logic [DIV_STEPS-1:0] CLAMP_MID = 21'd1048576;

   // floor division by 99 after the 2^14 shift, via reciprocal
   localparam logic [19:0] BIAS_99  = 20'd405504;    // 99 * 4096
   localparam logic [40:0] RECIP_99 = 41'd1355735;   // ceil(2^27 / 99)
   localparam int          SHIFT_99 = 27;

   // floor division by 5 after the 2^16 shift, via reciprocal
   localparam logic [15:0] BIAS_5   = 16'd20480;     // 5 * 4096
   localparam logic [32:0] RECIP_5  = 33'd104858;    // ceil(2^19 / 5)
   localparam int          SHIFT_5  = 19;

   localparam logic [15:0] BIAS_Q   = 16'd4096;

   // one stage of the two parallel dividers
   typedef struct packed {
      logic                    inv;
      logic                    cneg;
      logic                    sat1;
      logic                    sat2;
      logic signed [15:0]      pc;
      logic signed [15:0]      ps;
      logic [DEN_W-1:0]        den;
      logic [REM_W-1:0]        r1;
      logic [REM_W-1:0]        r2;
      logic [DIV_STEPS-1:0]    q1;
      logic [DIV_STEPS-1:0]    q2;
   } div_stage_type;

endpackage

`default_nettype wire

>>> rtl/sprite_screen_projection.sv
// Sprite screen projection: fully pipelined camera transform, dividers and wobble.
// Depends on ssp_pkg for constants and the divider stage type.
//
// Usage
//   Input channel req_*: sprite offset from the camera (Q10.14) and the cosine
//   and sine of its wobble phase (Q1.14). Result channel rsp_*: visible flag,
//   size in pixels, left column and top row. One result per transaction, in order.
//   Camera vectors and view offset must be written through csr_* while idle (unchecked).
// Path and throughput
//   Each transaction passes stages a to e, the divider stages, stages g to o
//   and the output register. One per cycle is accepted while req_stall is low;
//   the depth is set by the two 21-stage dividers (size and column), side by side.
// Reset
//   Synchronous, active high: clears every valid bit, empties the output and
//   skid registers and loads the camera registers with their defaults.
// Back-pressure
//   While rsp_stall holds a result, the next one lands in a skid register and
//   the pipeline keeps accepting; req_stall rises only once the skid register
//   is full, and then the whole pipeline holds without losing anything.
`default_nettype none

module sprite_screen_projection #(
   parameter int SCREEN_WIDTH  = 1024,
   parameter int SCREEN_HEIGHT = 768
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [23:0] req_offset_x,
   input  wire logic signed [23:0] req_offset_y,
   input  wire logic signed [15:0] req_phase_cos,
   input  wire logic signed [15:0] req_phase_sin,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_visible,
   output logic [10:0]             rsp_size_px,
   output logic signed [15:0]      rsp_column_px,
   output logic signed [15:0]      rsp_row_px,
   input  wire logic               csr_we,
   input  wire logic [2:0]         csr_index,
   input  wire logic [15:0]        csr_wdata
);
   import ssp_pkg::*;

   localparam int SW       = $clog2(2*SCREEN_HEIGHT+1);
   localparam int SIZE_MAX = 2*SCREEN_HEIGHT;
   localparam int HALF_W   = SCREEN_WIDTH/2;
   localparam int HALF_H   = SCREEN_HEIGHT/2;
   localparam logic signed [23:0] POS_MAX = 24'sd32767;
   localparam logic signed [23:0] POS_MIN = -24'sd32768;

   // configuration registers
   logic signed [15:0] dir_x_ff, dir_y_ff, plane_x_ff, plane_y_ff;
   logic signed [10:0] view_offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_x_ff       <= DIR_X_RESET;
         dir_y_ff       <= '0;
         plane_x_ff     <= '0;
         plane_y_ff     <= PLANE_Y_RESET;
         view_offset_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DIR_X:       dir_x_ff       <= csr_wdata;
            CSR_DIR_Y:       dir_y_ff       <= csr_wdata;
            CSR_PLANE_X:     plane_x_ff     <= csr_wdata;
            CSR_PLANE_Y:     plane_y_ff     <= csr_wdata;
            CSR_VIEW_OFFSET: view_offset_ff <= csr_wdata[10:0];
            default: ;
         endcase
      end
   end

   // pipeline advance: everything moves unless the skid register is full
   logic skid_v_ff;
   logic en;
   assign en        = !skid_v_ff;
   assign req_stall = skid_v_ff;

   // stage valid bits
   logic a_v_ff, b_v_ff, c_v_ff, d_v_ff, e_v_ff;
   logic dv_v_ff [0:DIV_STEPS];
   logic g_v_ff, h_v_ff, i_v_ff, j_v_ff, k_v_ff, l_v_ff, m_v_ff, n_v_ff, o_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0; b_v_ff <= 1'b0; c_v_ff <= 1'b0; d_v_ff <= 1'b0; e_v_ff <= 1'b0;
         for (int k = 0; k <= DIV_STEPS; k++) dv_v_ff[k] <= 1'b0;
         g_v_ff <= 1'b0; h_v_ff <= 1'b0; i_v_ff <= 1'b0; j_v_ff <= 1'b0; k_v_ff <= 1'b0;
         l_v_ff <= 1'b0; m_v_ff <= 1'b0; n_v_ff <= 1'b0; o_v_ff <= 1'b0;
      end else if (en) begin
         a_v_ff <= req_valid;
         b_v_ff <= a_v_ff; c_v_ff <= b_v_ff; d_v_ff <= c_v_ff; e_v_ff <= d_v_ff;
         dv_v_ff[0] <= e_v_ff;
         for (int k = 1; k <= DIV_STEPS; k++) dv_v_ff[k] <= dv_v_ff[k-1];
         g_v_ff <= dv_v_ff[DIV_STEPS];
         h_v_ff <= g_v_ff; i_v_ff <= h_v_ff; j_v_ff <= i_v_ff; k_v_ff <= j_v_ff;
         l_v_ff <= k_v_ff; m_v_ff <= l_v_ff; n_v_ff <= m_v_ff; o_v_ff <= n_v_ff;
      end
   end

   // stage a: camera matrix products
   logic signed [39:0] a_dyox_ff, a_dxoy_ff, a_pxoy_ff, a_pyox_ff;
   logic signed [31:0] a_pxdy_ff, a_dxpy_ff;
   logic signed [15:0] a_pc_ff, a_ps_ff;
   logic signed [39:0] a_dyox_in, a_dxoy_in, a_pxoy_in, a_pyox_in;
   logic signed [31:0] a_pxdy_in, a_dxpy_in;

   assign a_dyox_in = dir_y_ff   * req_offset_x;
   assign a_dxoy_in = dir_x_ff   * req_offset_y;
   assign a_pxoy_in = plane_x_ff * req_offset_y;
   assign a_pyox_in = plane_y_ff * req_offset_x;
   assign a_pxdy_in = plane_x_ff * dir_y_ff;
   assign a_dxpy_in = dir_x_ff   * plane_y_ff;

   // stage b: camera-space numerators and determinant
   logic signed [40:0] b_nx_ff, b_ny_ff, b_nx_in, b_ny_in;
   logic signed [32:0] b_det_ff, b_det_in;
   logic signed [15:0] b_pc_ff, b_ps_ff;

   assign b_nx_in  = 41'(a_dyox_ff) - 41'(a_dxoy_ff);
   assign b_ny_in  = 41'(a_pxoy_ff) - 41'(a_pyox_ff);
   assign b_det_in = 33'(a_pxdy_ff) - 33'(a_dxpy_ff);

   // stage c: visibility test, magnitudes and column numerator
   logic               c_inv_ff, c_cneg_ff, c_inv_in, c_cneg_in;
   logic [32:0]        c_adet_ff, c_adet_in;
   logic [40:0]        c_any_ff, c_any_in;
   logic signed [41:0] c_s_ff, c_s_in;
   logic signed [15:0] c_pc_ff, c_ps_ff;

   assign c_inv_in  = (b_det_ff == '0) || (b_ny_ff == '0) || (b_ny_ff[40] != b_det_ff[32]);
   assign c_adet_in = b_det_ff[32] ? 33'(-b_det_ff) : 33'(b_det_ff);
   assign c_any_in  = b_ny_ff[40] ? 41'(-b_ny_ff) : 41'(b_ny_ff);
   assign c_s_in    = 42'(b_nx_ff) + 42'(b_ny_ff);
   assign c_cneg_in = c_s_in[41] ^ b_ny_ff[40];

   // stage d: size numerator and column magnitude
   logic               d_inv_ff, d_cneg_ff;
   logic [REM_W-1:0]   d_n1_ff, d_n1_in;
   logic [41:0]        d_as_ff, d_as_in;
   logic [DEN_W-1:0]   d_den_ff;
   logic signed [15:0] d_pc_ff, d_ps_ff;

   assign d_n1_in = REM_W'(c_adet_ff) * REM_W'(SCREEN_HEIGHT);
   assign d_as_in = c_s_ff[41] ? 42'(-c_s_ff) : 42'(c_s_ff);

   // stage e: column numerator scaled by half the width
   logic               e_inv_ff, e_cneg_ff;
   logic [REM_W-1:0]   e_n1_ff, e_n2_ff, e_n2_in;
   logic [DEN_W-1:0]   e_den_ff;
   logic signed [15:0] e_pc_ff, e_ps_ff;

   assign e_n2_in = REM_W'(d_as_ff) * REM_W'(HALF_W);

   // divider entry: overflow checks, then one quotient bit per stage
   div_stage_type dv_ff [0:DIV_STEPS];
   div_stage_type dv_in [0:DIV_STEPS];
   logic [REM_W-1:0] den_top;

   assign den_top = REM_W'(e_den_ff) << DIV_STEPS;

   always_comb begin
      dv_in[0].inv  = e_inv_ff;
      dv_in[0].cneg = e_cneg_ff;
      dv_in[0].sat1 = e_n1_ff >= den_top;
      dv_in[0].sat2 = e_n2_ff >= den_top;
      dv_in[0].pc   = e_pc_ff;
      dv_in[0].ps   = e_ps_ff;
      dv_in[0].den  = e_den_ff;
      dv_in[0].r1   = e_n1_ff;
      dv_in[0].r2   = e_n2_ff;
      dv_in[0].q1   = '0;
      dv_in[0].q2   = '0;
      for (int k = 1; k <= DIV_STEPS; k++) begin
         dv_in[k] = dv_ff[k-1];
         if (dv_ff[k-1].r1 >= (REM_W'(dv_ff[k-1].den) << (DIV_STEPS-k))) begin
            dv_in[k].r1 = dv_ff[k-1].r1 - (REM_W'(dv_ff[k-1].den) << (DIV_STEPS-k));
            dv_in[k].q1[DIV_STEPS-k] = 1'b1;
         end
         if (dv_ff[k-1].r2 >= (REM_W'(dv_ff[k-1].den) << (DIV_STEPS-k))) begin
            dv_in[k].r2 = dv_ff[k-1].r2 - (REM_W'(dv_ff[k-1].den) << (DIV_STEPS-k));
            dv_in[k].q2[DIV_STEPS-k] = 1'b1;
         end
      end
   end

   // stage g: clamp size and column magnitude
   logic                 g_inv_ff, g_cneg_ff;
   logic [SW-1:0]        g_size_ff, g_size_in;
   logic [DIV_STEPS-1:0] g_cmag_ff, g_cmag_in;
   logic signed [15:0]   g_pc_ff, g_ps_ff;
   div_stage_type        dv_last;

   assign dv_last   = dv_ff[DIV_STEPS];
   assign g_size_in = (dv_last.sat1 || dv_last.q1 > DIV_STEPS'(SIZE_MAX))
                      ? SW'(SIZE_MAX) : SW'(dv_last.q1);
   assign g_cmag_in = (dv_last.sat2 || dv_last.q2 > CLAMP_MID) ? CLAMP_MID : dv_last.q2;

   // stage h: base column and row, wobble products
   logic               h_inv_ff;
   logic [SW-1:0]      h_size_ff;
   logic signed [23:0] h_cx_ff, h_cy_ff, h_cx_in, h_cy_in, h_cs;
   logic signed [31:0] h_p1_ff, h_p2_ff, h_p1_in, h_p2_in;

   assign h_cs    = $signed(24'(g_cmag_ff));
   assign h_cx_in = (g_cneg_ff ? -h_cs : h_cs) - $signed(24'(g_size_ff >> 1));
   assign h_cy_in = $signed(24'(HALF_H)) + 24'(view_offset_ff) - $signed(24'(g_size_ff >> 1));
   assign h_p1_in = g_pc_ff * $signed({1'b0, g_size_ff});
   assign h_p2_in = g_ps_ff * $signed({1'b0, g_size_ff});

   // stage i: cosine term times ten, row wobble split
   logic               i_inv_ff, i_lz2_ff, i_lz2_in;
   logic [SW-1:0]      i_size_ff;
   logic signed [23:0] i_cx_ff, i_cy_ff;
   logic signed [35:0] i_w1_ff, i_w1_in;
   logic [15:0]        i_a2_ff, i_a2_in;

   assign i_w1_in  = 36'(h_p1_ff) * 36'sd10;
   assign i_a2_in  = 16'(h_p2_ff >>> 16) + BIAS_5;
   assign i_lz2_in = |h_p2_ff[15:0];

   // stage j: column wobble split, row reciprocal product
   logic               j_inv_ff, j_lz1_ff, j_lz2_ff, j_lz1_in;
   logic [SW-1:0]      j_size_ff;
   logic signed [23:0] j_cx_ff, j_cy_ff;
   logic [19:0]        j_a1_ff, j_a1_in;
   logic [15:0]        j_a2_ff;
   logic [32:0]        j_m2_ff, j_m2_in;

   assign j_a1_in  = 20'(i_w1_ff >>> 14) + BIAS_99;
   assign j_lz1_in = |i_w1_ff[13:0];
   assign j_m2_in  = 33'(i_a2_ff) * RECIP_5;

   // stage k: column reciprocal product, row floor quotient
   logic               k_inv_ff, k_lz1_ff, k_lz2_ff;
   logic [SW-1:0]      k_size_ff;
   logic signed [23:0] k_cx_ff, k_cy_ff;
   logic [19:0]        k_a1_ff;
   logic [15:0]        k_a2_ff;
   logic [40:0]        k_m1_ff, k_m1_in;
   logic signed [15:0] k_fl2_ff, k_fl2_in;
   logic [16:0]        k_p5_ff, k_p5_in;
   logic [13:0]        k_q2;

   assign k_m1_in  = 41'(j_a1_ff) * RECIP_99;
   assign k_q2     = j_m2_ff[SHIFT_5 +: 14];
   assign k_fl2_in = $signed(16'(k_q2) - BIAS_Q);
   assign k_p5_in  = 17'(k_q2) * 17'd5;

   // stage l: column floor quotient, row floor sum and remainder test
   logic               l_inv_ff, l_lz1_ff, l_r2nz_ff, l_r2nz_in;
   logic [SW-1:0]      l_size_ff;
   logic signed [23:0] l_cx_ff, l_f2_ff, l_f2_in;
   logic [19:0]        l_a1_ff;
   logic signed [15:0] l_fl1_ff, l_fl1_in;
   logic [20:0]        l_p99_ff, l_p99_in;
   logic [13:0]        l_q1;

   assign l_q1      = k_m1_ff[SHIFT_99 +: 14];
   assign l_fl1_in  = $signed(16'(l_q1) - BIAS_Q);
   assign l_p99_in  = 21'(l_q1) * 21'd99;
   assign l_r2nz_in = k_lz2_ff || (17'(k_a2_ff) != k_p5_ff);
   assign l_f2_in   = k_cy_ff + 24'(k_fl2_ff);

   // stage m: column floor sum and remainder test
   logic               m_inv_ff, m_r1nz_ff, m_r2nz_ff, m_r1nz_in;
   logic [SW-1:0]      m_size_ff;
   logic signed [23:0] m_f1_ff, m_f2_ff, m_f1_in;

   assign m_r1nz_in = l_lz1_ff || (21'(l_a1_ff) != l_p99_ff);
   assign m_f1_in   = l_cx_ff + 24'(l_fl1_ff);

   // stage n: floor to truncation toward zero
   logic               n_inv_ff;
   logic [SW-1:0]      n_size_ff;
   logic signed [23:0] n_col_ff, n_row_ff, n_col_in, n_row_in;

   assign n_col_in = m_f1_ff + $signed(24'(m_f1_ff[23] && m_r1nz_ff));
   assign n_row_in = m_f2_ff + $signed(24'(m_f2_ff[23] && m_r2nz_ff));

   // stage o: screen edge tests, saturation, hidden results
   logic               o_vis_ff, o_vis_in, n_offscreen;
   logic [10:0]        o_size_ff, o_size_in;
   logic signed [15:0] o_col_ff, o_row_ff, o_col_in, o_row_in, n_col_sat, n_row_sat;
   logic [25:0]        n_col_end, n_row_end;
   logic [SW+10:0]     n_size_ext;

   assign n_col_end   = 26'(n_col_ff) + 26'(n_size_ff);
   assign n_row_end   = 26'(n_row_ff) + 26'(n_size_ff);
   assign n_offscreen = n_col_end[25] || (n_col_ff >= $signed(24'(SCREEN_WIDTH))) ||
                        n_row_end[25];
   assign n_col_sat   = (n_col_ff > POS_MAX) ? 16'sh7fff :
                        (n_col_ff < POS_MIN) ? 16'sh8000 : n_col_ff[15:0];
   assign n_row_sat   = (n_row_ff > POS_MAX) ? 16'sh7fff :
                        (n_row_ff < POS_MIN) ? 16'sh8000 : n_row_ff[15:0];
   assign n_size_ext  = (SW+11)'(n_size_ff);
   assign o_vis_in    = !n_inv_ff && !n_offscreen;
   assign o_size_in   = n_inv_ff ? '0 : n_size_ext[10:0];
   assign o_col_in    = n_inv_ff ? '0 : n_col_sat;
   assign o_row_in    = n_inv_ff ? '0 : n_row_sat;

   // pipeline payload registers
   always_ff @(posedge clock) begin
      if (en) begin
         a_dyox_ff <= a_dyox_in; a_dxoy_ff <= a_dxoy_in;
         a_pxoy_ff <= a_pxoy_in; a_pyox_ff <= a_pyox_in;
         a_pxdy_ff <= a_pxdy_in; a_dxpy_ff <= a_dxpy_in;
         a_pc_ff   <= req_phase_cos; a_ps_ff <= req_phase_sin;

         b_nx_ff  <= b_nx_in; b_ny_ff <= b_ny_in; b_det_ff <= b_det_in;
         b_pc_ff  <= a_pc_ff; b_ps_ff <= a_ps_ff;

         c_inv_ff <= c_inv_in; c_cneg_ff <= c_cneg_in; c_adet_ff <= c_adet_in;
         c_any_ff <= c_any_in; c_s_ff <= c_s_in; c_pc_ff <= b_pc_ff; c_ps_ff <= b_ps_ff;

         d_inv_ff <= c_inv_ff; d_cneg_ff <= c_cneg_ff; d_n1_ff <= d_n1_in;
         d_as_ff  <= d_as_in; d_den_ff <= c_any_ff; d_pc_ff <= c_pc_ff; d_ps_ff <= c_ps_ff;

         e_inv_ff <= d_inv_ff; e_cneg_ff <= d_cneg_ff; e_n1_ff <= d_n1_ff;
         e_n2_ff  <= e_n2_in; e_den_ff <= d_den_ff; e_pc_ff <= d_pc_ff; e_ps_ff <= d_ps_ff;

         for (int k = 0; k <= DIV_STEPS; k++) dv_ff[k] <= dv_in[k];

         g_inv_ff <= dv_last.inv; g_cneg_ff <= dv_last.cneg; g_size_ff <= g_size_in;
         g_cmag_ff <= g_cmag_in; g_pc_ff <= dv_last.pc; g_ps_ff <= dv_last.ps;

         h_inv_ff <= g_inv_ff; h_size_ff <= g_size_ff; h_cx_ff <= h_cx_in;
         h_cy_ff  <= h_cy_in; h_p1_ff <= h_p1_in; h_p2_ff <= h_p2_in;

         i_inv_ff <= h_inv_ff; i_size_ff <= h_size_ff; i_cx_ff <= h_cx_ff;
         i_cy_ff  <= h_cy_ff; i_w1_ff <= i_w1_in; i_a2_ff <= i_a2_in; i_lz2_ff <= i_lz2_in;

         j_inv_ff <= i_inv_ff; j_size_ff <= i_size_ff; j_cx_ff <= i_cx_ff;
         j_cy_ff  <= i_cy_ff; j_a1_ff <= j_a1_in; j_lz1_ff <= j_lz1_in;
         j_a2_ff  <= i_a2_ff; j_lz2_ff <= i_lz2_ff; j_m2_ff <= j_m2_in;

         k_inv_ff <= j_inv_ff; k_size_ff <= j_size_ff; k_cx_ff <= j_cx_ff;
         k_cy_ff  <= j_cy_ff; k_a1_ff <= j_a1_ff; k_lz1_ff <= j_lz1_ff;
         k_m1_ff  <= k_m1_in; k_a2_ff <= j_a2_ff; k_lz2_ff <= j_lz2_ff;
         k_fl2_ff <= k_fl2_in; k_p5_ff <= k_p5_in;

         l_inv_ff <= k_inv_ff; l_size_ff <= k_size_ff; l_cx_ff <= k_cx_ff;
         l_f2_ff  <= l_f2_in; l_r2nz_ff <= l_r2nz_in; l_a1_ff <= k_a1_ff;
         l_lz1_ff <= k_lz1_ff; l_fl1_ff <= l_fl1_in; l_p99_ff <= l_p99_in;

         m_inv_ff <= l_inv_ff; m_size_ff <= l_size_ff; m_f1_ff <= m_f1_in;
         m_r1nz_ff <= m_r1nz_in; m_f2_ff <= l_f2_ff; m_r2nz_ff <= l_r2nz_ff;

         n_inv_ff <= m_inv_ff; n_size_ff <= m_size_ff;
         n_col_ff <= n_col_in; n_row_ff <= n_row_in;

         o_vis_ff <= o_vis_in; o_size_ff <= o_size_in;
         o_col_ff <= o_col_in; o_row_ff <= o_row_in;
      end
   end

   // output register and skid register control
   logic               rsp_valid_ff, out_free;
   logic               rsp_vis_ff, skid_vis_ff;
   logic [10:0]        rsp_size_ff, skid_size_ff;
   logic signed [15:0] rsp_col_ff, rsp_row_ff, skid_col_ff, skid_row_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_v_ff    <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= skid_v_ff || o_v_ff;
         skid_v_ff    <= 1'b0;
      end else if (o_v_ff && en) begin
         skid_v_ff    <= 1'b1;
      end
   end

   // output and skid payload
   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_v_ff) begin
            rsp_vis_ff  <= skid_vis_ff;  rsp_size_ff <= skid_size_ff;
            rsp_col_ff  <= skid_col_ff;  rsp_row_ff  <= skid_row_ff;
         end else begin
            rsp_vis_ff  <= o_vis_ff;     rsp_size_ff <= o_size_ff;
            rsp_col_ff  <= o_col_ff;     rsp_row_ff  <= o_row_ff;
         end
      end else if (en) begin
         skid_vis_ff  <= o_vis_ff;  skid_size_ff <= o_size_ff;
         skid_col_ff  <= o_col_ff;  skid_row_ff  <= o_row_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_visible   = rsp_vis_ff;
   assign rsp_size_px   = rsp_size_ff;
   assign rsp_column_px = rsp_col_ff;
   assign rsp_row_px    = rsp_row_ff;

endmodule

`default_nettype wire

>>> rtl/ssp_checker.sv
// Port-level checks for the sprite screen projection block.
// Depends on sprite_screen_projection; attached through the bind below.
`default_nettype none

module ssp_checker #(
   parameter int SCREEN_WIDTH = 1024
) (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_stall,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic               rsp_visible,
   input wire logic [10:0]        rsp_size_px,
   input wire logic signed [15:0] rsp_column_px,
   input wire logic signed [15:0] rsp_row_px
);

   // reset empties the output side
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid && !req_stall)
      else $error("output not empty after reset");

   // input back-pressure only while a result is waiting
   a_stall_needs_result: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no result pending");

   // a stalled transaction is held
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_visible) &&
      $stable(rsp_size_px) && $stable(rsp_column_px) && $stable(rsp_row_px))
      else $error("stalled transaction changed");

   // a drawn sprite starts left of the right edge
   a_visible_on_screen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_visible |-> rsp_column_px < SCREEN_WIDTH)
      else $error("visible sprite starts beyond the right edge");

endmodule

bind sprite_screen_projection ssp_checker #(.SCREEN_WIDTH(SCREEN_WIDTH)) u_ssp_checker (
   .clock         (clock),
   .reset         (reset),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_visible   (rsp_visible),
   .rsp_size_px   (rsp_size_px),
   .rsp_column_px (rsp_column_px),
   .rsp_row_px    (rsp_row_px)
);

`default_nettype wire

>>> test/sprite_screen_projection_tb.sv
// Testbench for the sprite screen projection block: directed and random sprites,
// several camera settings, random input gaps and output stalls, checked against a predictor.
// Depends on ssp_pkg for the register indexes and on the sprite_screen_projection RTL.

class projection_scoreboard;
   // camera settings mirrored from the register writes
   longint dir_x, dir_y, plane_x, plane_y, view_offset;
   logic [43:0] pending[$];   // {visible, size, column, row}
   int          n_errors;
   int          n_checked;

   function new();
      dir_x = 16384; dir_y = 0; plane_x = 0; plane_y = 10813; view_offset = 0;
      n_errors = 0; n_checked = 0;
   endfunction

   function void set_register(logic [2:0] idx, logic [15:0] value);
      case (idx)
         ssp_pkg::CSR_DIR_X:       dir_x = longint'($signed(value));
         ssp_pkg::CSR_DIR_Y:       dir_y = longint'($signed(value));
         ssp_pkg::CSR_PLANE_X:     plane_x = longint'($signed(value));
         ssp_pkg::CSR_PLANE_Y:     plane_y = longint'($signed(value));
         ssp_pkg::CSR_VIEW_OFFSET: view_offset = longint'($signed(value[10:0]));
         default: ;
      endcase
   endfunction

   // project one sprite and queue the expected result
   function void note_sprite(logic signed [23:0] ox_in, logic signed [23:0] oy_in,
                             logic signed [15:0] pc_in, logic signed [15:0] ps_in);
      longint ox, oy, pc, ps, det, nx, ny, q, sz, cx, cy, col, row, adet, any;
      logic vis;
      ox = ox_in; oy = oy_in; pc = pc_in; ps = ps_in;
      det = plane_x * dir_y - dir_x * plane_y;
      nx = dir_y * ox - dir_x * oy;
      ny = plane_x * oy - plane_y * ox;
      if (det == 0 || ny == 0 || ((ny > 0) != (det > 0))) begin
         pending.push_back(44'd0);
         return;
      end
      adet = det < 0 ? -det : det;
      any = ny < 0 ? -ny : ny;
      q = (768 * adet) / any;
      sz = q > 1536 ? 1536 : q;
      cx = (512 * (nx + ny)) / ny;
      if (cx > 1048576) cx = 1048576;
      if (cx < -1048576) cx = -1048576;
      cx = cx - sz / 2;
      col = (cx * (16384 * 99) + pc * sz * 10) / (16384 * 99);
      cy = -(sz / 2) + 384 + view_offset;
      row = (cy * (16384 * 20) + ps * sz) / (16384 * 20);
      vis = !(col + sz < 0 || col >= 1024 || row + sz < 0);
      if (col > 32767) col = 32767;
      if (col < -32768) col = -32768;
      if (row > 32767) row = 32767;
      if (row < -32768) row = -32768;
      pending.push_back({vis, sz[10:0], col[15:0], row[15:0]});
   endfunction

   function void check_result(logic vis, logic [10:0] sz, logic [15:0] col,
                              logic [15:0] row);
      logic [43:0] exp_r;
      if (pending.size() == 0) begin
         $error("result with no sprite outstanding");
         n_errors++;
         return;
      end
      exp_r = pending.pop_front();
      n_checked++;
      if (vis !== exp_r[43]) begin
         $error("visible: expected %0d actual %0d", exp_r[43], vis); n_errors++;
      end
      if (sz !== exp_r[42:32]) begin
         $error("size_px: expected %0d actual %0d", exp_r[42:32], sz); n_errors++;
      end
      if (col !== exp_r[31:16]) begin
         $error("column_px: expected %0d actual %0d", $signed(exp_r[31:16]),
                $signed(col));
         n_errors++;
      end
      if (row !== exp_r[15:0]) begin
         $error("row_px: expected %0d actual %0d", $signed(exp_r[15:0]),
                $signed(row));
         n_errors++;
      end
   endfunction
endclass

module sprite_screen_projection_tb;
   import ssp_pkg::*;

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_stall;
   logic signed [23:0] req_offset_x = 0;
   logic signed [23:0] req_offset_y = 0;
   logic signed [15:0] req_phase_cos = 0;
   logic signed [15:0] req_phase_sin = 0;
   logic               rsp_valid;
   logic               rsp_stall = 0;
   logic               rsp_visible;
   logic [10:0]        rsp_size_px;
   logic signed [15:0] rsp_column_px;
   logic signed [15:0] rsp_row_px;
   logic               csr_we = 0;
   logic [2:0]         csr_index = 0;
   logic [15:0]        csr_wdata = 0;

   projection_scoreboard board = new();
   bit  sink_hold_off = 0;   // long receiver hold-off in progress
   bit  stimulus_done = 0;
   int  n_visible = 0;

   sprite_screen_projection uut (.*);

   always #6 clock = ~clock;

   // receiver: random stall lengths, plus one long hold-off on request
   initial begin : sink
      int gap;
      @(posedge clock);
      forever begin
         if (sink_hold_off) begin
            rsp_stall <= 1;
            repeat (200) @(posedge clock);
            sink_hold_off = 0;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
         if ($urandom_range(0, 4) == 0) gap = 0;
         if (gap > 0) begin
            rsp_stall <= 1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // check every result transaction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rsp_visible) n_visible++;
         board.check_result(rsp_visible, rsp_size_px, rsp_column_px, rsp_row_px);
      end
   end

   task automatic write_register(logic [2:0] idx, logic [15:0] value);
      csr_we <= 1; csr_index <= idx; csr_wdata <= value;
      @(posedge clock);
      board.set_register(idx, value);
      csr_we <= 0;
   endtask

   task automatic set_camera(logic [15:0] dx, logic [15:0] dy, logic [15:0] px,
                             logic [15:0] py, logic [15:0] vo);
      write_register(CSR_DIR_X, dx);
      write_register(CSR_DIR_Y, dy);
      write_register(CSR_PLANE_X, px);
      write_register(CSR_PLANE_Y, py);
      write_register(CSR_VIEW_OFFSET, vo);
   endtask

   // offer one sprite transaction, with a random idle gap first
   task automatic send_sprite(logic [23:0] ox, logic [23:0] oy, logic [15:0] pc,
                              logic [15:0] ps, bit no_gap);
      int gap;
      gap = (no_gap || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_offset_x <= ox; req_offset_y <= oy;
      req_phase_cos <= pc; req_phase_sin <= ps;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_sprite(ox, oy, pc, ps);
   endtask

   task automatic wait_drained();
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (45) @(posedge clock);
   endtask

   function automatic logic [15:0] trig_value();
      case ($urandom_range(0, 4))
         0: return 16'sd16384;
         1: return -16'sd16384;
         2: return 16'd0;
         default: return 16'($signed($urandom_range(0, 32768)) - 16384);
      endcase
   endfunction

   // mostly modest offsets in any direction, with some full-range noise
   task automatic random_sprites(int count, bit no_gap);
      logic [23:0] ox, oy;
      repeat (count) begin
         if ($urandom_range(0, 4) == 0) begin
            ox = 24'($urandom); oy = 24'($urandom);
         end else begin
            ox = 24'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            oy = 24'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
         end
         send_sprite(ox, oy, trig_value(), trig_value(), no_gap);
      end
   endtask

   initial begin : stimulus
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: reset camera, in front, behind, extremes, far edges
      send_sprite(24'sd16384 * 3, 24'sd0, 16'sd0, 16'sd0, 0);
      send_sprite(-24'sd16384, 24'sd0, 16'sd0, 16'sd0, 0);
      send_sprite(24'sd0, 24'sd0, 16'sd16384, -16'sd16384, 0);
      send_sprite(24'h7fffff, 24'h7fffff, 16'sd16384, 16'sd16384, 0);
      send_sprite(24'h800000, 24'h800000, -16'sd16384, -16'sd16384, 0);
      send_sprite(24'sd1, 24'sd0, 16'sd16384, 16'sd16384, 0);
      send_sprite(24'sd1, 24'h7fffff, -16'sd16384, 16'sd0, 0);
      send_sprite(24'sd1, 24'h800000, 16'sd0, -16'sd16384, 0);
      send_sprite(24'sd16384, 24'sd16384 * 5, 16'sd0, 16'sd0, 0);
      send_sprite(24'sd16384, -24'sd16384 * 5, 16'sd0, 16'sd0, 0);
      send_sprite(24'h7fffff, 24'sd0, 16'hffff, 16'h0001, 0);
      send_sprite(24'h555555, 24'haaaaaa, 16'h5555, 16'haaaa, 0);
      wait_drained();

      // degenerate matrix: zero determinant
      set_camera(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      send_sprite(24'sd16384, 24'sd0, 16'sd0, 16'sd0, 0);
      wait_drained();
      // register extremes and view offsets of +768 and -768
      set_camera(16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'(11'sd768));
      random_sprites(8, 0);
      send_sprite(24'sd1, 24'sd1, 16'sd0, 16'sd0, 0);
      wait_drained();
      set_camera(16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'(-11'sd768));
      random_sprites(8, 0);
      wait_drained();
      // unused register index is ignored
      write_register(3'd7, 16'hffff);
      write_register(3'd5, 16'h1234);
      set_camera(16'h0, 16'sd16384, -16'sd10813, 16'h0, 16'h7ff);
      random_sprites(300, 0);

      // long receiver hold-off while the sender keeps offering back to back
      sink_hold_off = 1;
      random_sprites(120, 1);
      wait_drained();

      set_camera(16'sd16384, 16'sd0, 16'sd0, 16'sd10813, 16'sd0);
      random_sprites(400, 0);
      wait_drained();
      set_camera(-16'sd11585, 16'sd11585, -16'sd7646, -16'sd7646, 16'(-11'sd100));
      random_sprites(300, 0);
      wait_drained();
      set_camera(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 16'(11'($urandom_range(0, 1536) - 768)));
      random_sprites(350, 0);
      wait_drained();

      $display("covered %0d sprites (%0d visible) over several camera settings",
               board.n_checked, n_visible);
      if (board.n_errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   initial begin : watchdog
      #(12 * 400000);
      $display("FAIL");
      $finish;
   end
endmodule
